FILE: hdl/assert_macros.svh
// Assertion macros used by the allocator RTL. They expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)

`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

FILE: hdl/fpfa_pkg.sv
`default_nettype none

package fpfa_pkg;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIT_POLICY  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BLOCK_COUNT = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic mark;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic found;
  } scan_t;

endpackage

`default_nettype wire

FILE: hdl/fpfa_cell.sv
`default_nettype none

module fpfa_cell #(
  parameter int IDX_BITS  = 4,
  parameter int SIZE_BITS = 32,
  parameter int CNT_BITS  = 5,
  parameter int INDEX     = 0
) (
  input  wire                  clk,
  input  wire                  rst,
  input  fpfa_pkg::cmd_t       cmd,
  input  wire [IDX_BITS-1:0]   cmd_index,
  input  wire [SIZE_BITS-1:0]  load_size,
  input  wire [SIZE_BITS-1:0]  req,
  input  wire [1:0]            policy,
  input  wire [CNT_BITS-1:0]   limit,
  input  fpfa_pkg::scan_t      in_ctrl,
  input  wire [IDX_BITS-1:0]   in_pick,
  input  wire [SIZE_BITS-1:0]  in_best,
  output fpfa_pkg::scan_t      out_ctrl,
  output logic [IDX_BITS-1:0]  out_pick,
  output logic [SIZE_BITS-1:0] out_best
);

  logic [SIZE_BITS-1:0] size;
  logic                 used;
  logic                 hit;
  logic                 fit;
  logic                 take;
  logic [SIZE_BITS-1:0] left;

  assign hit  = (cmd_index == IDX_BITS'(INDEX));
  assign left = size - req;
  assign fit  = in_ctrl.valid && (CNT_BITS'(INDEX) < limit) && !used && (size >= req);

  always_comb begin
    take = 1'b0;
    if (fit) begin
      if (!in_ctrl.found) begin
        take = 1'b1;
      end else if (policy == fpfa_pkg::POLICY_BEST) begin
        take = (left < in_best);
      end else if (policy == fpfa_pkg::POLICY_WORST) begin
        take = (left > in_best);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (cmd.clear) begin
      used <= 1'b0;
    end else if (cmd.mark && hit) begin
      used <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && hit) begin
      size <= load_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctrl <= '0;
    end else begin
      out_ctrl.valid <= in_ctrl.valid;
      out_ctrl.found <= in_ctrl.found || fit;
    end
  end

  always_ff @(posedge clk) begin
    out_pick <= take ? IDX_BITS'(INDEX) : in_pick;
    out_best <= take ? left : in_best;
  end

endmodule

`default_nettype wire

FILE: hdl/fixed_partition_fit_allocator.sv
// Fixed-partition allocator with first, best and worst fit policies.
// Requests arrive on the s_ channel; s_tuser carries the mode (load, allocate, clear).
// A load writes one partition size and a clear frees every partition; both are
// taken only while idle and give no result. An allocate request sends a scan
// token down a row of MAX_BLOCKS cells, one cell per cycle, and m_tvalid rises
// once the token has left the last cell and passed the result registers into
// the output register; the next request can be taken in the cycle m_tvalid rises.
// The walk of the token along the cell row paces the allocates; one allocate is in
// progress at a time and s_tready is low until its result is in the output register.
// A result waiting on a stalled m_ side does not stop loads, clears or the scan of
// the next allocate; that scan holds at its end until the output register frees.
// fit_policy and block_count are written on the cfg_ channel, which is always ready,
// and are to be written only while the block is idle.
// Reset frees every partition and clears both registers; partition sizes must be
// loaded before they are used.

`default_nettype none

`include "assert_macros.svh"

module fixed_partition_fit_allocator #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [71:0] s_tdata,   // load_index[3:0], block_size[35:4], request_size[67:36]
  input  wire  [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [39:0] m_tdata,   // granted_index[3:0], leftover[35:4]
  output logic [0:0]  m_tuser,   // granted[0]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [fpfa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire  [fpfa_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int IDX_BITS = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_BITS = $clog2(MAX_BLOCKS + 1);
  localparam int LI_BITS  = (IDX_BITS > 4) ? IDX_BITS + 1 : 5;

  fpfa_pkg::state_t state;
  fpfa_pkg::state_t state_next;

  logic [1:0]           policy;
  logic [CNT_BITS-1:0]  limit;
  logic [SIZE_BITS-1:0] req;
  logic                 launch_valid;
  logic                 res_found;
  logic [IDX_BITS-1:0]  res_pick;
  logic [SIZE_BITS-1:0] res_best;

  logic                 in_accept;
  logic                 put_result;
  logic [LI_BITS-1:0]   li_wide;
  logic                 li_ok;
  fpfa_pkg::cmd_t       cmd;
  logic [IDX_BITS-1:0]  cmd_index;
  logic [SIZE_BITS-1:0] load_size;

  fpfa_pkg::scan_t      ctrl_chain [MAX_BLOCKS+1];
  logic [IDX_BITS-1:0]  pick_chain [MAX_BLOCKS+1];
  logic [SIZE_BITS-1:0] best_chain [MAX_BLOCKS+1];
  logic [MAX_BLOCKS:0]  chain_valid;

  assign cfg_ready = 1'b1;
  assign in_accept = s_tvalid && s_tready;
  assign li_wide   = LI_BITS'(s_tdata[3:0]);
  assign li_ok     = (li_wide < LI_BITS'(MAX_BLOCKS));
  assign load_size = SIZE_BITS'(s_tdata[35:4]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpfa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    put_result = 1'b0;
    unique case (state)
      fpfa_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && (s_tuser == fpfa_pkg::MODE_ALLOC)) begin
          state_next = fpfa_pkg::ST_SCAN;
        end
      end
      fpfa_pkg::ST_SCAN: begin
        if (ctrl_chain[MAX_BLOCKS].valid) begin
          state_next = fpfa_pkg::ST_DONE;
        end
      end
      fpfa_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          put_result = 1'b1;
          state_next = fpfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fpfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load  = in_accept && (s_tuser == fpfa_pkg::MODE_LOAD) && li_ok;
    cmd.clear = in_accept && (s_tuser == fpfa_pkg::MODE_CLEAR);
    cmd.mark  = put_result && res_found;
    cmd_index = put_result ? res_pick : li_wide[IDX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= fpfa_pkg::POLICY_FIRST;
      limit  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == fpfa_pkg::CFG_FIT_POLICY) begin
        policy <= cfg_data[1:0];
      end else if (cfg_index == fpfa_pkg::CFG_BLOCK_COUNT) begin
        if (32'(cfg_data) > 32'(MAX_BLOCKS)) begin
          limit <= CNT_BITS'(MAX_BLOCKS);
        end else begin
          limit <= CNT_BITS'(cfg_data);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch_valid <= 1'b0;
    end else begin
      launch_valid <= in_accept && (s_tuser == fpfa_pkg::MODE_ALLOC);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && (s_tuser == fpfa_pkg::MODE_ALLOC)) begin
      req <= SIZE_BITS'(s_tdata[67:36]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_found <= 1'b0;
    end else if (ctrl_chain[MAX_BLOCKS].valid) begin
      res_found <= ctrl_chain[MAX_BLOCKS].found;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_chain[MAX_BLOCKS].valid) begin
      res_pick <= pick_chain[MAX_BLOCKS];
      res_best <= best_chain[MAX_BLOCKS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (put_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_result) begin
      m_tuser <= res_found;
      if (res_found) begin
        m_tdata <= {4'd0, 32'(res_best), 4'(res_pick)};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  assign ctrl_chain[0]  = '{valid: launch_valid, found: 1'b0};
  assign pick_chain[0]  = '0;
  assign best_chain[0]  = '0;
  assign chain_valid[0] = ctrl_chain[0].valid;

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    fpfa_cell #(
      .IDX_BITS  (IDX_BITS),
      .SIZE_BITS (SIZE_BITS),
      .CNT_BITS  (CNT_BITS),
      .INDEX     (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .cmd_index (cmd_index),
      .load_size (load_size),
      .req       (req),
      .policy    (policy),
      .limit     (limit),
      .in_ctrl   (ctrl_chain[i]),
      .in_pick   (pick_chain[i]),
      .in_best   (best_chain[i]),
      .out_ctrl  (ctrl_chain[i+1]),
      .out_pick  (pick_chain[i+1]),
      .out_best  (best_chain[i+1])
    );
    assign chain_valid[i+1] = ctrl_chain[i+1].valid;
  end

  `ASSERT_PROP(a_one_token, clk, rst, $onehot0(chain_valid), "more than one scan token in the cell row")
  `ASSERT_PROP(a_end_in_scan, clk, rst, chain_valid[MAX_BLOCKS] |-> (state == fpfa_pkg::ST_SCAN), "scan token left the row outside a scan")
  `ASSERT_NEVER(a_denied_clean, clk, rst, m_tvalid && !m_tuser[0] && (m_tdata != '0), "refused request carries a non-zero index or leftover")

endmodule

`default_nettype wire

FILE: sim/allocation_checker.sv
`timescale 1ns / 1ps

module allocation_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  input  wire         s_tready,
  input  wire  [71:0] s_tdata,
  input  wire  [1:0]  s_tuser,
  input  wire         m_tvalid,
  input  wire         m_tready,
  input  wire  [39:0] m_tdata,
  input  wire  [0:0]  m_tuser,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire  [fpfa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire  [fpfa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  wire         end_of_test,
  output int          errors,
  output int          pending
);

  localparam int PARTITIONS = 16;

  typedef struct packed {
    logic        granted;
    logic [3:0]  index;
    logic [31:0] leftover;
  } grant_t;

  grant_t                grant_q[$];
  logic [31:0]           part_size [PARTITIONS];
  logic [PARTITIONS-1:0] used;
  logic [1:0]            policy;
  logic [4:0]            count;
  bit                    end_seen;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("checker: %0t ns: %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic predict_grant(input logic [31:0] req, output grant_t g);
    int          limit;
    int          n;
    logic        found;
    logic        stop;
    logic [3:0]  pick;
    logic [31:0] best;
    logic [31:0] left;
    limit = (int'(count) > PARTITIONS) ? PARTITIONS : int'(count);
    found = 1'b0;
    stop = 1'b0;
    pick = '0;
    best = '0;
    for (n = 0; n < limit; n++) begin
      if (!stop && !used[n] && part_size[n] >= req) begin
        left = part_size[n] - req;
        if (!found) begin
          found = 1'b1;
          pick = n[3:0];
          best = left;
          stop = (policy != fpfa_pkg::POLICY_BEST) && (policy != fpfa_pkg::POLICY_WORST);
        end else if (policy == fpfa_pkg::POLICY_BEST && left < best) begin
          pick = n[3:0];
          best = left;
        end else if (policy == fpfa_pkg::POLICY_WORST && left > best) begin
          pick = n[3:0];
          best = left;
        end
      end
    end
    if (found) begin
      used[pick] = 1'b1;
    end
    g.granted = found;
    g.index = found ? pick : 4'd0;
    g.leftover = found ? best : 32'd0;
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      grant_q.delete();
      used = '0;
      policy = fpfa_pkg::POLICY_FIRST;
      count = '0;
      errors = 0;
      end_seen = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (grant_q.size() == 0) begin
          report_mismatch("result with no allocate request waiting", m_tdata[35:4], 32'd0);
        end else begin
          want = grant_q.pop_front();
          if (m_tuser[0] !== want.granted)
            report_mismatch("granted", 32'(m_tuser[0]), 32'(want.granted));
          if (m_tdata[3:0] !== want.index)
            report_mismatch("granted_index", 32'(m_tdata[3:0]), 32'(want.index));
          if (m_tdata[35:4] !== want.leftover)
            report_mismatch("leftover", m_tdata[35:4], want.leftover);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fpfa_pkg::CFG_FIT_POLICY:  policy = cfg_data[1:0];
          fpfa_pkg::CFG_BLOCK_COUNT: count = cfg_data[4:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        case (s_tuser)
          fpfa_pkg::MODE_LOAD:  part_size[s_tdata[3:0]] = s_tdata[35:4];
          fpfa_pkg::MODE_ALLOC: begin
            predict_grant(s_tdata[67:36], want);
            grant_q.push_back(want);
          end
          fpfa_pkg::MODE_CLEAR: used = '0;
          default: ;
        endcase
      end
      if (end_of_test && !end_seen) begin
        end_seen = 1'b1;
        if (grant_q.size() != 0)
          report_mismatch("results still expected at the end", 32'(grant_q.size()), 32'd0);
      end
    end
    pending <= grant_q.size();
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam logic [1:0] POLICY_SPARE = 2'd3;
  localparam int PHASES          = 13;
  localparam int PHASE_ITEMS     = 145;
  localparam int STALL_CYCLES    = 400;
  localparam int TAIL_CYCLES     = 30;
  localparam int WATCHDOG_CYCLES = 5000;

  logic                                clk;
  logic                                rst;
  logic                                s_tvalid;
  logic                                s_tready;
  logic [71:0]                         s_tdata;
  logic [1:0]                          s_tuser;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  logic [39:0]                         m_tdata;
  logic [0:0]                          m_tuser;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [fpfa_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [fpfa_pkg::CFG_DATA_BITS-1:0]  cfg_data;
  logic                                end_of_test;
  int                                  errors;
  int                                  pending;

  logic [15:0] loaded = '0;
  bit          gaps_on = 1'b1;
  logic        stall_req = 1'b0;
  bit          stall_done = 1'b0;
  int          stall_left = 0;
  int          idle_cycles = 0;

  fixed_partition_fit_allocator uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  allocation_checker alloc_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .end_of_test(end_of_test), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_req && !stall_done) begin
      stall_done = 1'b1;
      stall_left = STALL_CYCLES;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(gaps_on && $urandom_range(0, 99) < 8);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_size();
    if ($urandom_range(0, 3) != 0)
      return $urandom_range(0, 64);
    return $urandom;
  endfunction

  task automatic send_item(input logic [1:0] mode, input logic [3:0] idx,
                           input logic [31:0] bsize, input logic [31:0] req);
    while (gaps_on && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {4'b0, req, bsize, idx};
    do @(posedge clk); while (!s_tready);
    if (mode == fpfa_pkg::MODE_LOAD)
      loaded[idx] = 1'b1;
  endtask

  task automatic write_reg(input logic [fpfa_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [fpfa_pkg::CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic random_item(input int active, output bit counted);
    int          r;
    int          n;
    int          hole;
    logic [3:0]  idx;
    logic [1:0]  mode;
    r = $urandom_range(0, 99);
    hole = -1;
    if (r < 52) mode = fpfa_pkg::MODE_ALLOC;
    else if (r < 84) mode = fpfa_pkg::MODE_LOAD;
    else if (r < 92) mode = fpfa_pkg::MODE_CLEAR;
    else mode = MODE_IGNORED;
    idx = 4'($urandom_range(0, 15));
    if (mode == fpfa_pkg::MODE_LOAD && active > 0 && $urandom_range(0, 3) != 0)
      idx = 4'($urandom_range(0, active - 1));
    if (mode == fpfa_pkg::MODE_ALLOC) begin
      for (n = active - 1; n >= 0; n--) begin
        if (!loaded[n])
          hole = n;
      end
      if (hole >= 0) begin
        mode = fpfa_pkg::MODE_LOAD;
        idx = hole[3:0];
      end
    end
    send_item(mode, idx, rand_size(), rand_size());
    counted = (mode != MODE_IGNORED);
  endtask

  initial begin
    int         ph;
    int         done_items;
    int         active;
    bit         counted;
    logic [4:0] count_value;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= fpfa_pkg::MODE_LOAD;
    cfg_valid <= 1'b0;
    cfg_index <= fpfa_pkg::CFG_FIT_POLICY;
    cfg_data <= '0;
    end_of_test <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(fpfa_pkg::MODE_ALLOC, 4'($urandom), $urandom, 32'd0);
    send_item(MODE_IGNORED, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();
    write_reg(fpfa_pkg::CFG_BLOCK_COUNT, 5'd4);
    send_item(fpfa_pkg::MODE_LOAD, 4'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(fpfa_pkg::MODE_LOAD, 4'd1, 32'hFFFF_FFFF, 32'd0);
    send_item(fpfa_pkg::MODE_LOAD, 4'd2, 32'd100, $urandom);
    send_item(fpfa_pkg::MODE_LOAD, 4'd3, 32'd50, $urandom);
    send_item(fpfa_pkg::MODE_ALLOC, 4'($urandom), $urandom, 32'd0);
    send_item(fpfa_pkg::MODE_ALLOC, 4'($urandom), $urandom, 32'hFFFF_FFFF);
    send_item(fpfa_pkg::MODE_ALLOC, 4'($urandom), $urandom, 32'd40);
    send_item(fpfa_pkg::MODE_ALLOC, 4'($urandom), $urandom, 32'd40);
    send_item(fpfa_pkg::MODE_ALLOC, 4'($urandom), $urandom, 32'd1);
    send_item(fpfa_pkg::MODE_LOAD, 4'd2, 32'd200, $urandom);
    send_item(fpfa_pkg::MODE_ALLOC, 4'($urandom), $urandom, 32'd1);
    send_item(fpfa_pkg::MODE_CLEAR, 4'($urandom), $urandom, $urandom);
    wait_idle();
    write_reg(fpfa_pkg::CFG_FIT_POLICY, 5'(fpfa_pkg::POLICY_BEST));
    send_item(fpfa_pkg::MODE_ALLOC, 4'($urandom), $urandom, 32'd40);
    send_item(fpfa_pkg::MODE_ALLOC, 4'($urandom), $urandom, 32'd40);
    send_item(fpfa_pkg::MODE_CLEAR, 4'($urandom), $urandom, $urandom);
    wait_idle();
    write_reg(fpfa_pkg::CFG_FIT_POLICY, 5'(fpfa_pkg::POLICY_WORST));
    send_item(fpfa_pkg::MODE_ALLOC, 4'($urandom), $urandom, 32'd40);
    send_item(fpfa_pkg::MODE_ALLOC, 4'($urandom), $urandom, 32'd0);
    send_item(fpfa_pkg::MODE_CLEAR, 4'($urandom), $urandom, $urandom);
    wait_idle();
    write_reg(fpfa_pkg::CFG_FIT_POLICY, 5'(POLICY_SPARE));
    send_item(fpfa_pkg::MODE_ALLOC, 4'($urandom), $urandom, 32'd40);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_reg(fpfa_pkg::CFG_FIT_POLICY, 5'(ph % 4));
      case (ph)
        0:       count_value = 5'd1;
        1:       count_value = 5'd16;
        2:       count_value = 5'd31;
        3:       count_value = 5'd0;
        default: begin
          if ($urandom_range(0, 4) == 0)
            count_value = 5'($urandom_range(17, 31));
          else
            count_value = 5'($urandom_range(1, 16));
        end
      endcase
      write_reg(fpfa_pkg::CFG_BLOCK_COUNT, count_value);
      active = (int'(count_value) > 16) ? 16 : int'(count_value);
      gaps_on = (ph != 5);
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        if (ph == 6 && done_items == 20)
          stall_req <= 1'b1;
        if (ph == 7 && done_items == 70)
          wait_idle();
        random_item(active, counted);
        if (counted)
          done_items++;
      end
    end

    wait_idle();
    end_of_test <= 1'b1;
    repeat (2) @(posedge clk);
    if (errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

FILE: fixed_partition_fit_allocator.f
+incdir+hdl
hdl/fpfa_pkg.sv
hdl/fpfa_cell.sv
hdl/fixed_partition_fit_allocator.sv
sim/allocation_checker.sv
sim/testbench.sv
